>>> rtl/tcomp_pkg.sv
// ----------------------------------------------------------------------------
// tcomp_pkg
// Shared types and constants for the thermistor compensation core: the ADC
// threshold table, the temperature window, and the compensation constants.
// ----------------------------------------------------------------------------
package tcomp_pkg;

    // table size and value widths
    localparam int unsigned TBL_LEN   = 65;
    localparam int unsigned SMP_W     = 12;
    localparam int unsigned TEMP_W    = 7;
    localparam int unsigned OFS_W     = 6;
    localparam int unsigned CURVE_W   = 8;
    localparam int unsigned IDX_W     = 6;

    // descending adc thresholds, colder first
    localparam logic [SMP_W-1:0] ADC_THRESH [0:TBL_LEN-1] = '{
        12'd3714, 12'd3694, 12'd3673, 12'd3651, 12'd3628, 12'd3604, 12'd3579,
        12'd3553, 12'd3527, 12'd3499, 12'd3471, 12'd3442, 12'd3411, 12'd3380,
        12'd3348, 12'd3315, 12'd3282, 12'd3247, 12'd3211, 12'd3175, 12'd3138,
        12'd3100, 12'd3061, 12'd3022, 12'd2982, 12'd2941, 12'd2899, 12'd2857,
        12'd2815, 12'd2772, 12'd2728, 12'd2684, 12'd2639, 12'd2595, 12'd2550,
        12'd2504, 12'd2459, 12'd2413, 12'd2367, 12'd2321, 12'd2276, 12'd2230,
        12'd2184, 12'd2139, 12'd2093, 12'd2048, 12'd2003, 12'd1959, 12'd1914,
        12'd1870, 12'd1827, 12'd1784, 12'd1741, 12'd1699, 12'd1658, 12'd1617,
        12'd1577, 12'd1537, 12'd1498, 12'd1459, 12'd1421, 12'd1384, 12'd1348,
        12'd1312, 12'd1277
    };

    // temperature window and interval base
    localparam logic signed [TEMP_W-1:0] T_COLD    = -7'sd20;
    localparam logic signed [TEMP_W-1:0] T_HOT     = 7'sd45;
    localparam logic signed [TEMP_W-1:0] T_IDX_OFS = 7'sd19;

    // compensation reference points and clamp thresholds
    localparam logic signed [TEMP_W-1:0] REF_HI    = 7'sd25;
    localparam logic signed [TEMP_W-1:0] REF_LO    = 7'sd15;
    localparam logic signed [TEMP_W-1:0] CLAMP_TOP = 7'sd40;
    localparam logic signed [TEMP_W-1:0] STD_LOW   = -7'sd20;
    localparam logic signed [TEMP_W-1:0] BAND_LOW  = -7'sd10;
    localparam logic signed [TEMP_W-1:0] FLAT_LOW  = 7'sd0;

    // gains, scaled by 1/100 through a reciprocal multiply
    localparam int unsigned MAG_W  = 6;
    localparam int unsigned GAIN_W = 6;
    localparam int unsigned PROD_W = 11;
    localparam logic [GAIN_W-1:0] GAIN_STD  = 6'd40;
    localparam logic [GAIN_W-1:0] GAIN_BAND = 6'd30;
    localparam int unsigned RECIP_W     = 13;
    localparam int unsigned RECIP_SHIFT = 19;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
    localparam int unsigned QUOT_W = 5;

    // charge curve groups
    typedef enum logic [1:0] {
        GRP_STD,
        GRP_BAND,
        GRP_FLAT,
        GRP_NONE
    } t_curve_grp;

    // beat between lookup and offset stages
    typedef struct packed {
        logic                     vld;
        logic signed [TEMP_W-1:0] temp;
    } t_temp_beat;

endpackage

>>> rtl/tcomp_lookup.sv
// ----------------------------------------------------------------------------
// tcomp_lookup
// Two-stage table lookup: parallel threshold compares, then a thermometer
// decode of the compare vector into whole degrees.
// ----------------------------------------------------------------------------
module tcomp_lookup
    import tcomp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  logic [SMP_W-1:0]   i_sample,
    output t_temp_beat         o_beat
);

    localparam int unsigned NCMP = TBL_LEN - 1;

    logic              r_s1_vld;
    logic              r_s1_cold;
    logic              r_s1_hot;
    logic [NCMP:1]     r_s1_lt;
    logic [NCMP:1]     n_s1_lt;

    logic                     r_s2_vld;
    logic signed [TEMP_W-1:0] r_s2_temp;
    logic signed [TEMP_W-1:0] n_s2_temp;
    logic [IDX_W-1:0]         n_idx;

    // sample below each interior and last threshold
    always_comb begin
        for (int k = 1; k <= NCMP; k++) begin
            n_s1_lt[k] = (i_sample < ADC_THRESH[k]);
        end
    end

    // stage 1 valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_vld;
        end
    end

    // stage 1 compare vector and end flags
    always_ff @(posedge i_clk) begin
        r_s1_lt   <= n_s1_lt;
        r_s1_cold <= (i_sample >= ADC_THRESH[0]);
        r_s1_hot  <= (i_sample <= ADC_THRESH[TBL_LEN-1]);
    end

    // thermometer edge gives the interval number
    always_comb begin
        n_idx = '0;
        for (int k = 1; k < NCMP; k++) begin
            if (r_s1_lt[k] && !r_s1_lt[k+1]) begin
                n_idx = n_idx | IDX_W'(k);
            end
        end
        if (r_s1_lt[NCMP]) begin
            n_idx = n_idx | IDX_W'(NCMP);
        end
    end

    // end cases take priority over the interval
    always_comb begin
        if (r_s1_cold) begin
            n_s2_temp = T_COLD;
        end else if (r_s1_hot) begin
            n_s2_temp = T_HOT;
        end else begin
            n_s2_temp = $signed({1'b0, n_idx}) - T_IDX_OFS;
        end
    end

    // stage 2 valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    // stage 2 temperature
    always_ff @(posedge i_clk) begin
        r_s2_temp <= n_s2_temp;
    end

    assign o_beat.vld  = r_s2_vld;
    assign o_beat.temp = r_s2_temp;

endmodule

>>> rtl/tcomp_offset.sv
// ----------------------------------------------------------------------------
// tcomp_offset
// Two-stage compensation: curve clamps and dead band give a distance and a
// gain, then the scaled product is divided by 100 toward zero.
// ----------------------------------------------------------------------------
module tcomp_offset
    import tcomp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_temp_beat               i_beat,
    input  logic [CURVE_W-1:0]       i_curve,
    output logic                     o_vld,
    output logic signed [TEMP_W-1:0] o_temp,
    output logic signed [OFS_W-1:0]  o_ofs
);

    t_curve_grp               grp;
    logic signed [TEMP_W-1:0] diff;
    logic [GAIN_W-1:0]        gain;
    logic [MAG_W-1:0]         mag;

    logic                     r_s3_vld;
    logic signed [TEMP_W-1:0] r_s3_temp;
    logic                     r_s3_neg;
    logic [PROD_W-1:0]        r_s3_prod;

    logic [PROD_W+RECIP_W-1:0] quot_full;
    logic [QUOT_W-1:0]         quot;

    logic                     r_s4_vld;
    logic signed [TEMP_W-1:0] r_s4_temp;
    logic signed [OFS_W-1:0]  r_s4_ofs;
    logic signed [OFS_W-1:0]  n_s4_ofs;

    // curve group decode
    always_comb begin
        if (i_curve inside {[8'd1:8'd9]}) begin
            grp = GRP_STD;
        end else if (i_curve inside {[8'd10:8'd15]}) begin
            grp = GRP_BAND;
        end else if (i_curve inside {[8'd16:8'd21]}) begin
            grp = GRP_FLAT;
        end else begin
            grp = GRP_NONE;
        end
    end

    // clamped distance from the reference point and gain
    always_comb begin
        gain = GAIN_STD;
        diff = i_beat.temp - REF_HI;
        case (grp)
            GRP_STD: begin
                if (i_beat.temp <= STD_LOW) begin
                    diff = STD_LOW - REF_HI;
                end else if (i_beat.temp > CLAMP_TOP) begin
                    diff = CLAMP_TOP - REF_HI;
                end
            end
            GRP_BAND: begin
                gain = GAIN_BAND;
                if (i_beat.temp <= BAND_LOW) begin
                    diff = BAND_LOW - REF_LO;
                end else if (i_beat.temp > CLAMP_TOP) begin
                    diff = CLAMP_TOP - REF_HI;
                end else if (i_beat.temp <= REF_LO) begin
                    diff = i_beat.temp - REF_LO;
                end else if (i_beat.temp >= REF_HI) begin
                    diff = i_beat.temp - REF_HI;
                end else begin
                    diff = '0;
                end
            end
            GRP_FLAT: begin
                if (i_beat.temp <= FLAT_LOW) begin
                    diff = FLAT_LOW - REF_HI;
                end else if (i_beat.temp > CLAMP_TOP) begin
                    diff = CLAMP_TOP - REF_HI;
                end
            end
            default: begin
                diff = i_beat.temp - REF_HI;
            end
        endcase
    end

    // magnitude of the distance
    assign mag = diff[TEMP_W-1] ? MAG_W'(-diff) : MAG_W'(diff);

    // stage 3 valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= i_beat.vld;
        end
    end

    // stage 3 product magnitude and sign
    always_ff @(posedge i_clk) begin
        r_s3_temp <= i_beat.temp;
        r_s3_neg  <= diff[TEMP_W-1];
        r_s3_prod <= PROD_W'(mag) * PROD_W'(gain);
    end

    // divide by 100 via reciprocal, exact for products up to 1800
    assign quot_full = r_s3_prod * RECIP_100;
    assign quot      = quot_full[RECIP_SHIFT +: QUOT_W];
    assign n_s4_ofs  = r_s3_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

    // stage 4 valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else begin
            r_s4_vld <= r_s3_vld;
        end
    end

    // stage 4 result
    always_ff @(posedge i_clk) begin
        r_s4_temp <= r_s3_temp;
        r_s4_ofs  <= n_s4_ofs;
    end

    assign o_vld  = r_s4_vld;
    assign o_temp = r_s4_temp;
    assign o_ofs  = r_s4_ofs;

endmodule

>>> rtl/thermistor_temp_compensation_core.sv
// ----------------------------------------------------------------------------
// thermistor_temp_compensation_core
// Converts a thermistor adc sample to whole degrees and a charge offset.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_thermistor_sample and raise start; the beat is taken on any
//   edge where start is high and busy is low. A new sample may be given
//   every cycle.
//   Each beat yields one result: o_strobe is high for one
//   cycle with o_temperature_degrees and o_compensation_offset. Results
//   leave in the order samples came in; the receiver must take them then.
//   The registered steps, in order: threshold compares, thermometer decode,
//   curve clamp and gain multiply, reciprocal divide by 100.
//   Throughput is one sample per cycle while busy is low.
//   The curve number must be written through i_cfg_valid / o_cfg_ready /
//   i_cfg_data only while no samples are in flight; the block does not check.
//   Synchronous reset clears the pipeline valids and sets curve 0; busy is
//   high and o_cfg_ready low in reset, until the out-of-reset marker is set.
// ----------------------------------------------------------------------------
module thermistor_temp_compensation_core
    import tcomp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [SMP_W-1:0]         i_thermistor_sample,
    output logic                     o_strobe,
    output logic signed [TEMP_W-1:0] o_temperature_degrees,
    output logic signed [OFS_W-1:0]  o_compensation_offset,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CURVE_W-1:0]       i_cfg_data
);

    logic               r_run;
    logic [CURVE_W-1:0] r_curve;
    logic               in_beat;
    t_temp_beat         temp_beat;

    // out of reset marker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else begin
            r_run <= 1'b1;
        end
    end

    assign busy        = !r_run;
    assign o_cfg_ready = r_run;
    assign in_beat     = start && !busy;

    // curve select register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_curve <= i_cfg_data;
        end
    end

    // compare and decode stages
    tcomp_lookup u_lookup (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (in_beat),
        .i_sample (i_thermistor_sample),
        .o_beat   (temp_beat)
    );

    // clamp, multiply and divide stages
    tcomp_offset u_offset (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (temp_beat),
        .i_curve (r_curve),
        .o_vld   (o_strobe),
        .o_temp  (o_temperature_degrees),
        .o_ofs   (o_compensation_offset)
    );

endmodule

>>> tb/thermistor_temp_compensation_core_test.sv
// ----------------------------------------------------------------------------
// thermistor_temp_compensation_core_test
// Self-checking bench for the thermistor compensation core. Samples are
// queued with their idle odds, driven with start/busy and predicted as each
// beat is taken; every strobed result is checked against the oldest reading
// still owed. The curve register is rewritten between phases once the
// pipeline has drained, covering every curve group and its clamp edges.
// ----------------------------------------------------------------------------
module thermistor_temp_compensation_core_test;
    import tcomp_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 5;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RAND_PHASES  = 12;
    localparam int PHASE_ITEMS  = 84;

    // kinds of pending stimulus
    typedef enum logic {
        ITEM_SAMPLE,
        ITEM_CURVE
    } t_item_kind;

    typedef struct {
        t_item_kind  kind;
        int unsigned value;
        int unsigned idle_pct;
    } t_stim_item;

    // one owed result
    typedef struct {
        logic [SMP_W-1:0]         sample;
        logic signed [TEMP_W-1:0] temp;
        logic signed [OFS_W-1:0]  offset;
    } t_reading;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [SMP_W-1:0]         i_thermistor_sample = '0;
    logic                     o_strobe;
    logic signed [TEMP_W-1:0] o_temperature_degrees;
    logic signed [OFS_W-1:0]  o_compensation_offset;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CURVE_W-1:0]       i_cfg_data = '0;

    t_stim_item pending_q[$];
    t_reading   readings_owed_q[$];

    int   fail_count = 0;
    int   got_count = 0;
    int   sent_count = 0;
    int   cycle_count = 0;
    logic all_sent = 1'b0;

    // driver-private state
    int                 sent_total = 0;
    logic [CURVE_W-1:0] model_curve = '0;
    logic               start_next;
    logic               cfg_next;
    t_stim_item         head;

    thermistor_temp_compensation_core dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .start                 (start),
        .busy                  (busy),
        .i_thermistor_sample   (i_thermistor_sample),
        .o_strobe              (o_strobe),
        .o_temperature_degrees (o_temperature_degrees),
        .o_compensation_offset (o_compensation_offset),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_data            (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // table lookup plus curve-dependent offset for one sample
    function automatic t_reading predict_reading(logic [SMP_W-1:0] smp,
                                                 logic [CURVE_W-1:0] curve);
        t_reading   r;
        t_curve_grp grp;
        int         s;
        int         t;
        int         c;
        int         i;
        s = int'(smp);
        if (s >= int'(ADC_THRESH[0])) begin
            t = int'(T_COLD);
        end else if (s <= int'(ADC_THRESH[TBL_LEN-1])) begin
            t = int'(T_HOT);
        end else begin
            t = int'(T_HOT);
            // walk down so the lowest bracketing interval wins
            for (i = TBL_LEN - 2; i >= 0; i--) begin
                if (s <= int'(ADC_THRESH[i]) && s >= int'(ADC_THRESH[i+1])) begin
                    t = i - int'(T_IDX_OFS);
                end
            end
        end

        if (curve >= 1 && curve <= 9) begin
            grp = GRP_STD;
        end else if (curve >= 10 && curve <= 15) begin
            grp = GRP_BAND;
        end else if (curve >= 16 && curve <= 21) begin
            grp = GRP_FLAT;
        end else begin
            grp = GRP_NONE;
        end

        // lower clamp point itself takes the lower clamp value
        case (grp)
            GRP_STD: begin
                if (t <= int'(STD_LOW)) begin
                    c = ((int'(STD_LOW) - int'(REF_HI)) * int'(GAIN_STD)) / 100;
                end else if (t > int'(CLAMP_TOP)) begin
                    c = ((int'(CLAMP_TOP) - int'(REF_HI)) * int'(GAIN_STD)) / 100;
                end else begin
                    c = ((t - int'(REF_HI)) * int'(GAIN_STD)) / 100;
                end
            end
            GRP_BAND: begin
                if (t <= int'(BAND_LOW)) begin
                    c = ((int'(BAND_LOW) - int'(REF_LO)) * int'(GAIN_BAND)) / 100;
                end else if (t > int'(CLAMP_TOP)) begin
                    c = ((int'(CLAMP_TOP) - int'(REF_HI)) * int'(GAIN_BAND)) / 100;
                end else if (t <= int'(REF_LO)) begin
                    c = ((t - int'(REF_LO)) * int'(GAIN_BAND)) / 100;
                end else if (t >= int'(REF_HI)) begin
                    c = ((t - int'(REF_HI)) * int'(GAIN_BAND)) / 100;
                end else begin
                    c = 0;
                end
            end
            GRP_FLAT: begin
                if (t <= int'(FLAT_LOW)) begin
                    c = ((int'(FLAT_LOW) - int'(REF_HI)) * int'(GAIN_STD)) / 100;
                end else if (t > int'(CLAMP_TOP)) begin
                    c = ((int'(CLAMP_TOP) - int'(REF_HI)) * int'(GAIN_STD)) / 100;
                end else begin
                    c = ((t - int'(REF_HI)) * int'(GAIN_STD)) / 100;
                end
            end
            default: begin
                c = ((t - int'(REF_HI)) * int'(GAIN_STD)) / 100;
            end
        endcase

        r.sample = smp;
        r.temp   = t[TEMP_W-1:0];
        r.offset = c[OFS_W-1:0];
        return r;
    endfunction

    task automatic add_sample(int unsigned smp, int unsigned idle_pct);
        t_stim_item it;
        it.kind     = ITEM_SAMPLE;
        it.value    = smp;
        it.idle_pct = idle_pct;
        pending_q.push_back(it);
    endtask

    task automatic add_curve(int unsigned curve);
        t_stim_item it;
        it.kind     = ITEM_CURVE;
        it.value    = curve;
        it.idle_pct = 0;
        pending_q.push_back(it);
    endtask

    // driver: takes finished beats, then presents the next pending item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start       <= 1'b0;
            i_cfg_valid <= 1'b0;
            all_sent    <= 1'b0;
            model_curve = '0;
        end else begin
            start_next = start;
            cfg_next   = i_cfg_valid;
            // sample beat taken at this edge
            if (start && !busy) begin
                readings_owed_q.push_back(predict_reading(i_thermistor_sample,
                                                          model_curve));
                sent_total++;
                start_next = 1'b0;
            end
            // curve write taken at this edge
            if (i_cfg_valid && o_cfg_ready) begin
                model_curve = i_cfg_data;
                cfg_next    = 1'b0;
            end
            // next item; curve writes wait for the pipeline to drain
            if (!start_next && !cfg_next && pending_q.size() != 0) begin
                head = pending_q[0];
                if (head.kind == ITEM_CURVE) begin
                    if (got_count >= sent_total) begin
                        i_cfg_data <= head.value[CURVE_W-1:0];
                        cfg_next = 1'b1;
                        void'(pending_q.pop_front());
                    end
                end else if ($urandom_range(0, 99) >= head.idle_pct) begin
                    i_thermistor_sample <= head.value[SMP_W-1:0];
                    start_next = 1'b1;
                    void'(pending_q.pop_front());
                end
            end
            start       <= start_next;
            i_cfg_valid <= cfg_next;
            sent_count  <= sent_total;
            all_sent    <= (pending_q.size() == 0) && !start_next && !cfg_next;
        end
    end

    // monitor: every strobe retires the oldest owed reading
    always @(posedge i_clk) begin
        t_reading owed;
        if (i_rst_n && o_strobe) begin
            if (readings_owed_q.size() == 0) begin
                $error("result with nothing owed: temperature_degrees %0d, compensation_offset %0d",
                       o_temperature_degrees, o_compensation_offset);
                fail_count++;
            end else begin
                owed = readings_owed_q.pop_front();
                if (o_temperature_degrees !== owed.temp) begin
                    $error("temperature_degrees mismatch (sample %0d): expected %0d, actual %0d",
                           owed.sample, owed.temp, o_temperature_degrees);
                    fail_count++;
                end
                if (o_compensation_offset !== owed.offset) begin
                    $error("compensation_offset mismatch (sample %0d): expected %0d, actual %0d",
                           owed.sample, owed.offset, o_compensation_offset);
                    fail_count++;
                end
            end
            got_count <= got_count + 1;
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("thermistor_temp_compensation_core_test: FAIL");
            $finish;
        end
    end

    initial begin
        int          phase_curve[RAND_PHASES];
        int          idle_by_phase[4];
        int unsigned smp;
        int unsigned k;
        int unsigned j;

        idle_by_phase = '{0, 77, 0, 13};
        phase_curve   = '{1, 9, 10, 15, 16, 21, 22, 255, 0, -1, -2, -3};

        // directed: table ends with curve 0 from reset
        add_sample(0, 0);    add_sample(4095, 0); add_sample(3714, 0);
        add_sample(3713, 0); add_sample(1277, 0); add_sample(1278, 0);
        // standard group: lower clamp point, just above, top clamp edge
        add_curve(1);
        add_sample(3714, 0); add_sample(3700, 0); add_sample(1440, 0);
        add_sample(1400, 0);
        // band group: lower clamp, dead band edges, top clamp
        add_curve(10);
        add_sample(3480, 0); add_sample(3450, 0); add_sample(2520, 0);
        add_sample(2300, 0); add_sample(2070, 0); add_sample(1400, 0);
        // flat group: zero clamp point and just above
        add_curve(16);
        add_sample(3150, 0); add_sample(3120, 0); add_sample(1400, 0);
        // unclamped curve at both extremes
        add_curve(255);
        add_sample(4095, 0); add_sample(0, 0);

        // random phases, each with its own curve and idle odds
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (phase_curve[p])
                -1:      add_curve($urandom_range(1, 21));
                -2:      add_curve($urandom_range(0, 255));
                -3:      add_curve($urandom_range(10, 15));
                default: add_curve(phase_curve[p]);
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                k = $urandom_range(0, 9);
                if (k < 4) begin
                    smp = $urandom_range(0, 4095);
                end else if (k < 8) begin
                    // land on or right beside a table threshold
                    j   = $urandom_range(0, TBL_LEN - 1);
                    smp = int'(ADC_THRESH[j]) + $urandom_range(0, 4) - 2;
                end else begin
                    smp = $urandom_range(1277, 3714);
                end
                add_sample(smp, idle_by_phase[p % 4]);
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(all_sent && got_count >= sent_count)) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (readings_owed_q.size() != 0) begin
            $error("%0d readings never arrived", readings_owed_q.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("thermistor_temp_compensation_core_test: PASS");
        end else begin
            $display("thermistor_temp_compensation_core_test: FAIL");
        end
        $finish;
    end

endmodule
